[src/sccc_pkg.sv]
`default_nettype none
package sccc_pkg;

    localparam int ADDR_W      = 32;
    localparam int OFFSET_BITS = 6;
    localparam int SET_BITS    = 6;
    localparam int TAG_BITS    = ADDR_W - OFFSET_BITS - SET_BITS;
    localparam int NSETS       = 1 << SET_BITS;
    localparam int WAYS_DEF    = 4;
    localparam int COST_W      = 17;

    localparam logic [2:0] OP_PR_RD    = 3'd0;
    localparam logic [2:0] OP_PR_WR    = 3'd1;
    localparam logic [2:0] OP_SN_RD    = 3'd2;
    localparam logic [2:0] OP_SN_RDX   = 3'd3;
    localparam logic [2:0] OP_FILL     = 3'd4;

    localparam logic [1:0] LS_I = 2'd0;
    localparam logic [1:0] LS_S = 2'd1;
    localparam logic [1:0] LS_E = 2'd2;
    localparam logic [1:0] LS_M = 2'd3;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_RD    = 2'd1;
    localparam logic [1:0] BUS_RDX   = 2'd2;

    localparam logic [1:0] SN_NONE      = 2'd0;
    localparam logic [1:0] SN_SHARED    = 2'd1;
    localparam logic [1:0] SN_FLUSH_S   = 2'd2;
    localparam logic [1:0] SN_FLUSH_I   = 2'd3;

    localparam logic [1:0] CFG_PROTOCOL_MODE = 2'd0;
    localparam logic [1:0] CFG_HIT_COST      = 2'd1;
    localparam logic [1:0] CFG_MEMORY_COST   = 2'd2;

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic              shared_response;
    } t_in_item;

    typedef struct packed {
        logic                hit;
        logic [1:0]          bus_command;
        logic [SET_BITS-1:0] req_set;
        logic [TAG_BITS-1:0] req_tag;
        logic [COST_W-1:0]   request_cost;
        logic [1:0]          snoop_result;
        logic                evicted;
        logic [1:0]          new_state;
        logic                rejected;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ctrl_cmd;

endpackage
`default_nettype wire

[src/sccc_ctrl.sv]
`default_nettype none
module sccc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output sccc_pkg::t_ctrl_cmd     o_cmd
);
    import sccc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result register must be free or draining this cycle.
                o_cmd.commit = !r_out_valid || !i_out_stall;
                if (o_cmd.commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && i_out_stall);
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

[src/sccc_dp.sv]
`default_nettype none
module sccc_dp #(
    parameter int WAYS = sccc_pkg::WAYS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sccc_pkg::t_ctrl_cmd  i_cmd,
    input  wire sccc_pkg::t_in_item   i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    output sccc_pkg::t_out_item       o_out
);
    import sccc_pkg::*;

    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic [WAYS-1:0][TAG_BITS-1:0] tags;
        logic [WAYS-1:0][1:0]          states;
        logic [WAYS-1:0][AW-1:0]       ages;
    } t_row;

    t_row                r_mem [NSETS];
    t_row                r_rd, row_n;
    logic [WAYS-1:0]     r_present [NSETS];
    logic [WAYS-1:0]     pres, pres_n;

    logic                r_mode;
    logic [7:0]          r_hit_cost;
    logic [15:0]         r_mem_cost;

    logic                r_pv, pv_n, r_pw, pw_n;
    logic [ADDR_W-1:0]   r_pa, pa_n;

    logic [2:0]          r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_shr;
    logic [SET_BITS-1:0] r_set, rd_set;

    logic [TAG_BITS-1:0] cur_tag;
    logic [WAYS-1:0]     match;
    logic                found, free_found;
    logic [AW-1:0]       fw, freew, vw, tw;
    logic [AW-1:0]       best;
    logic [AW:0]         old_age;
    logic [1:0]          st, st2;
    logic                is_hit;
    t_out_item           res;

    assign pres = r_present[r_set];
    assign rd_set = (i_in.opcode == OP_FILL) ? r_pa[OFFSET_BITS +: SET_BITS]
                                             : i_in.address[OFFSET_BITS +: SET_BITS];
    assign cur_tag = (r_op == OP_FILL) ? r_pa[OFFSET_BITS + SET_BITS +: TAG_BITS]
                                       : r_addr[OFFSET_BITS + SET_BITS +: TAG_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[r_set] <= row_n;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSETS; k++) begin
                r_present[k] <= '0;
            end
            r_mode     <= 1'b0;
            r_hit_cost <= 8'd1;
            r_mem_cost <= 16'd100;
            r_pv       <= 1'b0;
            r_pw       <= 1'b0;
            r_pa       <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_present[r_set] <= pres_n;
                r_pv             <= pv_n;
                r_pw             <= pw_n;
                r_pa             <= pa_n;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROTOCOL_MODE: r_mode     <= i_cfg_data[0];
                    CFG_HIT_COST:      r_hit_cost <= i_cfg_data[7:0];
                    CFG_MEMORY_COST:   r_mem_cost <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in.opcode;
            r_addr <= i_in.address;
            r_shr  <= i_in.shared_response;
            r_set  <= rd_set;
        end
        if (i_cmd.commit) begin
            o_out <= res;
        end
    end

    // Way selection: lowest matching way, lowest free way, oldest present way.
    always_comb begin
        match      = '0;
        found      = 1'b0;
        fw         = '0;
        free_found = 1'b0;
        freew      = '0;
        vw         = '0;
        best       = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = pres[w] && (r_rd.tags[w] == cur_tag);
            if (match[w]) begin
                found = 1'b1;
                fw    = AW'(w);
            end
            if (!pres[w]) begin
                free_found = 1'b1;
                freew      = AW'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (r_rd.ages[w] > best) begin
                best = r_rd.ages[w];
                vw   = AW'(w);
            end
        end
        tw = found ? fw : (free_found ? freew : vw);
    end

    always_comb begin
        row_n   = r_rd;
        pres_n  = pres;
        pv_n    = r_pv;
        pw_n    = r_pw;
        pa_n    = r_pa;
        res     = '0;
        is_hit  = 1'b0;
        st2     = LS_I;
        old_age = '0;
        st      = found ? r_rd.states[fw] : LS_I;
        case (r_op)
            OP_PR_RD, OP_PR_WR: begin
                if (r_pv) begin
                    res.rejected = 1'b1;
                end else begin
                    res.req_set = r_set;
                    res.req_tag = cur_tag;
                    if (r_op == OP_PR_RD) begin
                        is_hit = (st == LS_M) || (st == LS_S) || (r_mode && st == LS_E);
                    end else begin
                        is_hit = (st == LS_M) || (r_mode && st == LS_E);
                    end
                    st2 = st;
                    if (is_hit) begin
                        res.hit          = 1'b1;
                        res.request_cost = COST_W'(r_hit_cost);
                        if (r_op == OP_PR_WR) begin
                            st2 = LS_M;
                        end
                        row_n.states[fw] = st2;
                    end else begin
                        res.bus_command  = (r_op == OP_PR_RD) ? BUS_RD : BUS_RDX;
                        res.request_cost = COST_W'(r_mem_cost);
                        // A write miss to a full set pays for the write-back too.
                        if (r_op == OP_PR_WR && !found && (&pres)) begin
                            res.request_cost = {r_mem_cost, 1'b0};
                        end
                        pv_n = 1'b1;
                        pw_n = (r_op == OP_PR_WR);
                        pa_n = r_addr;
                    end
                    res.new_state = st2;
                end
            end
            OP_SN_RD, OP_SN_RDX: begin
                res.req_set = r_set;
                res.req_tag = cur_tag;
                if (found) begin
                    st2 = st;
                    if (r_op == OP_SN_RD) begin
                        if (st == LS_S) begin
                            res.snoop_result = SN_SHARED;
                        end else if (st == LS_M) begin
                            res.snoop_result = SN_FLUSH_S;
                            st2 = LS_S;
                        end else if (st == LS_E && r_mode) begin
                            res.snoop_result = SN_SHARED;
                            st2 = LS_S;
                        end
                    end else begin
                        if (st == LS_M) begin
                            res.snoop_result = SN_FLUSH_I;
                            st2 = LS_I;
                        end else if (st == LS_S || (st == LS_E && r_mode)) begin
                            st2 = LS_I;
                        end
                    end
                    row_n.states[fw] = st2;
                    res.new_state    = st2;
                end
            end
            OP_FILL: begin
                if (!r_pv) begin
                    res.rejected = 1'b1;
                end else begin
                    res.req_set = r_set;
                    res.req_tag = cur_tag;
                    res.evicted = !found && !free_found;
                    old_age = pres[tw] ? {1'b0, r_rd.ages[tw]} : (AW + 1)'(WAYS);
                    for (int w = 0; w < WAYS; w++) begin
                        if (AW'(w) != tw && pres[w] && ({1'b0, r_rd.ages[w]} < old_age)
                            && ({1'b0, r_rd.ages[w]} < (AW + 1)'(WAYS - 1))) begin
                            row_n.ages[w] = r_rd.ages[w] + 1'b1;
                        end
                    end
                    row_n.ages[tw] = '0;
                    row_n.tags[tw] = cur_tag;
                    pres_n[tw]     = 1'b1;
                    if (r_pw) begin
                        st2 = LS_M;
                    end else if (r_mode && !r_shr) begin
                        st2 = LS_E;
                    end else begin
                        st2 = LS_S;
                    end
                    row_n.states[tw] = st2;
                    res.new_state    = st2;
                    pv_n = 1'b0;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[src/snooping_cache_coherence_controller_unit.sv]
`default_nettype none
// Each transaction is a read-modify-write of one set row: the indexed set is
// read from the tag and state memory in the accept cycle and written back, with
// the result registered, when the execute state commits, which waits while a
// held result is stalled at the output. No new transaction is accepted before that commit.
// Reset is synchronous, active low: all ways become not present, no miss is
// pending and the registers return to MSI, hit cost 1, memory cost 100.
module snooping_cache_coherence_controller_unit #(
    parameter int WAYS = sccc_pkg::WAYS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire sccc_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output sccc_pkg::t_out_item      o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import sccc_pkg::*;

    t_ctrl_cmd cmd;

    assign o_cfg_ready = 1'b1;

    sccc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    sccc_dp #(.WAYS(WAYS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("transaction accepted while another is in progress");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result valid without a committed transaction");

    a_hit_no_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.hit && (o_out.bus_command != BUS_NONE)))
        else $error("hit reported together with a bus request");
endmodule
`default_nettype wire

[verif/tb_snooping_cache_coherence_controller_unit.sv]
`default_nettype none
module tb_snooping_cache_coherence_controller_unit;
    import sccc_pkg::*;

    localparam int NWAYS = WAYS_DEF;
    localparam int LIMIT_CYCLES = 400000;

    // Mirror of the cache directory, the pending miss and the registers.
    class coherence_scoreboard;
        logic [TAG_BITS-1:0] tags[NSETS*NWAYS];
        logic [1:0]          states[NSETS*NWAYS];
        bit                  present[NSETS*NWAYS];
        int                  age[NSETS*NWAYS];
        logic [ADDR_W-1:0]   miss_addr;
        bit                  miss_write;
        bit                  miss_valid;
        bit                  mesi;
        logic [7:0]          hit_cost;
        logic [15:0]         mem_cost;
        t_out_item           expected_q[$];
        int                  errors;

        function void clear();
            for (int i = 0; i < NSETS*NWAYS; i++) begin
                tags[i] = '0;
                states[i] = LS_I;
                present[i] = 0;
                age[i] = 0;
            end
            miss_addr = '0;
            miss_write = 0;
            miss_valid = 0;
            mesi = 0;
            hit_cost = 8'd1;
            mem_cost = 16'd100;
            expected_q.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            if (idx == CFG_PROTOCOL_MODE) mesi = data[0];
            else if (idx == CFG_HIT_COST) hit_cost = data[7:0];
            else if (idx == CFG_MEMORY_COST) mem_cost = data;
        endfunction

        function int lookup(int s, logic [TAG_BITS-1:0] t);
            for (int w = 0; w < NWAYS; w++)
                if (present[s*NWAYS+w] && tags[s*NWAYS+w] == t) return w;
            return -1;
        endfunction

        function void promote(int s, int way);
            int me;
            int prev;
            me = s*NWAYS + way;
            prev = present[me] ? age[me] : NWAYS;
            for (int w = 0; w < NWAYS; w++)
                if (w != way && present[s*NWAYS+w] && age[s*NWAYS+w] < prev
                        && age[s*NWAYS+w] < NWAYS-1)
                    age[s*NWAYS+w]++;
            age[me] = 0;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int s, w, i, k, best;
            logic [TAG_BITS-1:0] t;
            logic [1:0] st;
            bit full, is_hit;
            r = '0;
            s = int'(it.address[OFFSET_BITS +: SET_BITS]);
            t = it.address[ADDR_W-1 -: TAG_BITS];
            case (it.opcode)
                OP_PR_RD, OP_PR_WR: begin
                    if (miss_valid) begin
                        r.rejected = 1;
                    end else begin
                        w = lookup(s, t);
                        st = (w >= 0) ? states[s*NWAYS+w] : LS_I;
                        r.req_set = SET_BITS'(s);
                        r.req_tag = t;
                        if (it.opcode == OP_PR_RD)
                            is_hit = st == LS_M || st == LS_S || (mesi && st == LS_E);
                        else
                            is_hit = st == LS_M || (mesi && st == LS_E);
                        if (is_hit) begin
                            r.hit = 1;
                            r.request_cost = COST_W'(hit_cost);
                            if (it.opcode == OP_PR_WR) st = LS_M;
                            states[s*NWAYS+w] = st;
                        end else begin
                            r.bus_command = (it.opcode == OP_PR_RD) ? BUS_RD : BUS_RDX;
                            r.request_cost = COST_W'(mem_cost);
                            full = 1;
                            for (k = 0; k < NWAYS; k++)
                                if (!present[s*NWAYS+k]) full = 0;
                            if (it.opcode == OP_PR_WR && w < 0 && full)
                                r.request_cost = {mem_cost, 1'b0};
                            miss_valid = 1;
                            miss_write = (it.opcode == OP_PR_WR);
                            miss_addr = it.address;
                        end
                        r.new_state = st;
                    end
                end
                OP_SN_RD, OP_SN_RDX: begin
                    w = lookup(s, t);
                    r.req_set = SET_BITS'(s);
                    r.req_tag = t;
                    if (w >= 0) begin
                        i = s*NWAYS + w;
                        st = states[i];
                        if (it.opcode == OP_SN_RD) begin
                            if (st == LS_S) r.snoop_result = SN_SHARED;
                            else if (st == LS_M) begin
                                r.snoop_result = SN_FLUSH_S;
                                st = LS_S;
                            end else if (st == LS_E && mesi) begin
                                r.snoop_result = SN_SHARED;
                                st = LS_S;
                            end
                        end else begin
                            if (st == LS_M) begin
                                r.snoop_result = SN_FLUSH_I;
                                st = LS_I;
                            end else if (st == LS_S || (st == LS_E && mesi)) begin
                                st = LS_I;
                            end
                        end
                        states[i] = st;
                        r.new_state = st;
                    end
                end
                OP_FILL: begin
                    if (!miss_valid) begin
                        r.rejected = 1;
                    end else begin
                        s = int'(miss_addr[OFFSET_BITS +: SET_BITS]);
                        t = miss_addr[ADDR_W-1 -: TAG_BITS];
                        w = lookup(s, t);
                        r.req_set = SET_BITS'(s);
                        r.req_tag = t;
                        if (w < 0) begin
                            for (k = 0; k < NWAYS && w < 0; k++)
                                if (!present[s*NWAYS+k]) w = k;
                            if (w < 0) begin
                                best = 0;
                                w = 0;
                                for (k = 0; k < NWAYS; k++)
                                    if (age[s*NWAYS+k] > best) begin
                                        best = age[s*NWAYS+k];
                                        w = k;
                                    end
                                r.evicted = 1;
                            end
                            promote(s, w);
                            present[s*NWAYS+w] = 1;
                            tags[s*NWAYS+w] = t;
                        end else begin
                            promote(s, w);
                        end
                        if (miss_write) st = LS_M;
                        else if (mesi && !it.shared_response) st = LS_E;
                        else st = LS_S;
                        states[s*NWAYS+w] = st;
                        r.new_state = st;
                        miss_valid = 0;
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, got.hit); errors++; end
            if (got.bus_command !== e.bus_command) begin
                $error("bus_command exp %0d got %0d", e.bus_command, got.bus_command);
                errors++; end
            if (got.req_set !== e.req_set) begin
                $error("req_set exp %0d got %0d", e.req_set, got.req_set); errors++; end
            if (got.req_tag !== e.req_tag) begin
                $error("req_tag exp %h got %h", e.req_tag, got.req_tag); errors++; end
            if (got.request_cost !== e.request_cost) begin
                $error("request_cost exp %0d got %0d", e.request_cost, got.request_cost);
                errors++; end
            if (got.snoop_result !== e.snoop_result) begin
                $error("snoop_result exp %0d got %0d", e.snoop_result, got.snoop_result);
                errors++; end
            if (got.evicted !== e.evicted) begin
                $error("evicted exp %0d got %0d", e.evicted, got.evicted); errors++; end
            if (got.new_state !== e.new_state) begin
                $error("new_state exp %0d got %0d", e.new_state, got.new_state); errors++; end
            if (got.rejected !== e.rejected) begin
                $error("rejected exp %0d got %0d", e.rejected, got.rejected); errors++; end
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_in_valid = 0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 0;
    t_out_item o_out;
    logic      i_cfg_valid = 0;
    logic      o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    coherence_scoreboard sb;
    bit   quiet = 0;
    bit   hold_rx = 0;
    int   cycles = 0;
    logic [ADDR_W-1:0] hot_addr[8];

    snooping_cache_coherence_controller_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_snooping_cache_coherence_controller_unit: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);

    // Receiver: random stall bursts, or a long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1;
                repeat (60) @(posedge i_clk);
                i_out_stall <= 0;
                hold_rx = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                i_out_stall <= 1;
                repeat (n - 1) @(posedge i_clk);
                @(posedge i_clk);
                i_out_stall <= 0;
            end
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // Valid stays high after the accepting edge; the next call replaces the
    // payload in the same step, and drain() or an idle burst drops valid.
    task automatic send(logic [2:0] op, logic [ADDR_W-1:0] a, bit shr);
        t_in_item it;
        it.opcode = op;
        it.address = a;
        it.shared_response = shr;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 3))
            0: a = $urandom();
            default: a = hot_addr[$urandom_range(0, 7)];
        endcase
        a[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom());
        return a;
    endfunction

    task automatic random_phase(int count);
        logic [ADDR_W-1:0] a;
        int r;
        for (int n = 0; n < count; n++) begin
            a = pick_addr();
            r = $urandom_range(0, 99);
            // Mostly access-then-fill pairs so lines get installed and reused.
            if (r < 60) begin
                send($urandom_range(0, 1) ? OP_PR_WR : OP_PR_RD, a, 1'b0);
                if (sb.miss_valid && $urandom_range(0, 9) != 0)
                    send(OP_FILL, $urandom(), 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                send($urandom_range(0, 1) ? OP_SN_RDX : OP_SN_RD, a, 1'b0);
            end else begin
                send(3'($urandom_range(0, 7)), $urandom(), 1'($urandom_range(0, 1)));
            end
        end
        if (sb.miss_valid) send(OP_FILL, '0, 1'b0);
    endtask

    initial begin
        sb = new();
        sb.clear();
        // Six tags sharing one hot set plus two in a second set force evictions.
        for (int k = 0; k < 8; k++) begin
            hot_addr[k] = $urandom();
            hot_addr[k][OFFSET_BITS +: SET_BITS] = (k < 6) ? 6'd5 : 6'd63;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: under MSI, then MESI.
        send(OP_FILL, 32'hFFFF_FFFF, 1'b1);              // fill with nothing pending
        send(OP_PR_RD, 32'h0000_0000, 1'b0);
        send(OP_PR_WR, 32'hFFFF_FFFF, 1'b0);             // refused while a miss waits
        send(OP_FILL, '0, 1'b1);
        send(OP_PR_RD, 32'h0000_0000, 1'b0);             // hit in S
        send(OP_PR_WR, 32'h0000_0000, 1'b0);             // upgrade miss
        send(OP_FILL, '0, 1'b0);
        send(OP_SN_RD, 32'h0000_0000, 1'b0);             // flush to S
        send(OP_SN_RDX, 32'h0000_0000, 1'b0);            // invalidate
        send(OP_SN_RDX, 32'h0000_0000, 1'b0);            // present but invalid
        send(3'd5, 32'h1234_5678, 1'b1);
        send(3'd7, 32'hFFFF_FFFF, 1'b1);
        drain();
        write_cfg(CFG_PROTOCOL_MODE, 16'd1);
        write_cfg(CFG_HIT_COST, 16'd255);
        write_cfg(CFG_MEMORY_COST, 16'hFFFF);
        for (int k = 0; k < 5; k++) begin
            send(OP_PR_WR, hot_addr[k], 1'b0);           // fifth write finds the set full
            send(OP_FILL, '0, 1'b0);
        end
        send(OP_PR_RD, hot_addr[6], 1'b0);
        send(OP_FILL, '0, 1'b0);                         // exclusive
        send(OP_SN_RD, hot_addr[6], 1'b0);
        drain();

        random_phase(300);
        drain();
        write_cfg(CFG_PROTOCOL_MODE, 16'd0);             // leftover E lines under MSI
        write_cfg(CFG_HIT_COST, 16'd0);
        write_cfg(CFG_MEMORY_COST, 16'd0);
        hold_rx = 1;
        random_phase(300);
        drain();
        write_cfg(CFG_PROTOCOL_MODE, 16'd1);
        write_cfg(CFG_HIT_COST, 16'($urandom_range(0, 255)));
        write_cfg(CFG_MEMORY_COST, 16'($urandom_range(0, 65535)));
        random_phase(300);
        drain();
        quiet = 1;
        random_phase(150);
        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_snooping_cache_coherence_controller_unit: done, clean");
        else
            $display("tb_snooping_cache_coherence_controller_unit: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
src/sccc_pkg.sv
src/sccc_ctrl.sv
src/sccc_dp.sv
src/snooping_cache_coherence_controller_unit.sv
verif/tb_snooping_cache_coherence_controller_unit.sv
